// File: rtl/chs_pkg.sv
package chs_pkg;

    localparam int CoordW = 16;

    typedef struct packed {
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] x;
    } t_point;

    typedef enum logic [31:0] {
        S_LOAD     = 32'h0000_0001,
        S_SORT_RD  = 32'h0000_0002,
        S_SORT_V   = 32'h0000_0004,
        S_SORT_J   = 32'h0000_0008,
        S_SORT_CMP = 32'h0000_0010,
        S_MM_RD    = 32'h0000_0020,
        S_MM_CMP   = 32'h0000_0040,
        S_DECIDE   = 32'h0000_0080,
        S_SC_START = 32'h0000_0100,
        S_SC_RS    = 32'h0000_0200,
        S_SC_RE    = 32'h0000_0400,
        S_SC_W1    = 32'h0000_0800,
        S_SC_W2    = 32'h0000_1000,
        S_SC_CHK   = 32'h0000_2000,
        S_SC_FN    = 32'h0000_4000,
        S_SC_MUL   = 32'h0000_8000,
        S_SC_DEC   = 32'h0001_0000,
        S_SC_WB2   = 32'h0002_0000,
        S_SC_POP1  = 32'h0004_0000,
        S_SC_POP2  = 32'h0008_0000,
        S_SC_DONE  = 32'h0010_0000,
        S_STOP_RD  = 32'h0020_0000,
        S_STOP_CAP = 32'h0040_0000,
        S_CHK_RD   = 32'h0080_0000,
        S_CHK_CAP  = 32'h0100_0000,
        S_CHK_P1   = 32'h0200_0000,
        S_CHK_P2   = 32'h0400_0000,
        S_EM_NEXT  = 32'h0800_0000,
        S_EM_IDX   = 32'h1000_0000,
        S_EM_PT    = 32'h2000_0000,
        S_EM_PUSH  = 32'h4000_0000,
        S_FLUSH    = 32'h8000_0000
    } t_state;

endpackage

// File: rtl/convex_hull_sklansky_top.sv
// Points load one beat per cycle into a point memory; the beat marked last starts the hull
// computation, during which no input is taken. The set is insertion-sorted in place in the
// point memory (quadratic in the point count), the lowest and highest points are found in a
// pass over the sorted points, and each Sklansky scan step runs on index-stack and
// point-memory traffic. Vertices then leave one by one, held back by output stall. The
// single read port of the point memory paces all of these steps. Once the final vertex is
// handed to the output register, the block takes points again. Configuration may be written
// at any time the block is idle.
module convex_hull_sklansky_top #(
    parameter int MAX_POINTS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [chs_pkg::CoordW-1:0]  i_point_x,
    input  logic signed [chs_pkg::CoordW-1:0]  i_point_y,
    input  logic                               i_last_point,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [chs_pkg::CoordW-1:0]  o_hull_x,
    output logic signed [chs_pkg::CoordW-1:0]  o_hull_y,
    output logic                               o_hull_last,
    output logic                               o_overflow,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_counter_clockwise
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;
    localparam int IW = AW + 2;
    localparam int SD = MAX_POINTS + 2;
    localparam int SW = $clog2(SD);
    localparam int XW = SW + 2;
    localparam int GUARD = 8 * MAX_POINTS + 16;
    localparam int GW = $clog2(GUARD + 1);
    localparam int DW = chs_pkg::CoordW + 1;
    localparam int MW = 2 * DW;

    chs_pkg::t_state r_state, n_state;
    logic r_ccw, n_ccw;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_drop, n_drop;
    logic [CW-1:0] r_si, n_si, r_sj, n_sj, r_mi, n_mi;
    chs_pkg::t_point r_v, n_v;
    logic signed [IW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic signed [chs_pkg::CoordW-1:0] r_loy, n_loy, r_hiy, n_hiy;
    chs_pkg::t_point r_p0, n_p0, r_plast, n_plast;
    logic [1:0] r_phase, n_phase;
    logic signed [IW-1:0] r_sc_start, n_sc_start, r_sc_end, n_sc_end;
    logic [SW:0] r_sc_base, n_sc_base;
    logic r_sc_npos, n_sc_npos, r_sc_spos, n_sc_spos, r_dec, n_dec;
    logic signed [IW-1:0] r_prv, n_prv, r_cur, n_cur, r_nxt, n_nxt, r_endadj, n_endadj;
    logic [SW:0] r_size, n_size;
    logic [GW-1:0] r_guard, n_guard;
    chs_pkg::t_point r_pprv, n_pprv, r_pcur, n_pcur, r_pnxt, n_pnxt;
    logic signed [DW-1:0] r_by, n_by;
    logic signed [MW-1:0] r_m1, n_m1, r_m2, n_m2;
    logic r_anz, n_anz;
    logic [SW:0] r_scnt, n_scnt, r_lc0, n_lc0;
    logic [SW:0] r_lb, n_lb, r_lc, n_lc, r_rb, n_rb, r_rc, n_rc;
    logic signed [IW-1:0] r_stop, n_stop;
    logic r_stop_v, n_stop_v, r_chk_v, n_chk_v;
    chs_pkg::t_point r_pa, n_pa;
    logic r_em_side, n_em_side;
    logic [SW:0] r_em_i, n_em_i;
    chs_pkg::t_point r_new, n_new, r_pend, n_pend;
    logic r_pend_v, n_pend_v;
    logic [CW-1:0] r_hcnt, n_hcnt;
    logic r_out_valid, n_out_valid;
    chs_pkg::t_point r_out_pt, n_out_pt;
    logic r_out_last, n_out_last, r_out_ovf, n_out_ovf;

    logic p_we;
    logic [AW-1:0] p_waddr, p_raddr;
    chs_pkg::t_point p_wdata, p_rdata;
    logic s_we;
    logic [SW-1:0] s_waddr, s_raddr;
    logic [IW-1:0] s_wdata, s_rdata;

    logic w_out_free;
    logic signed [DW-1:0] w_ax, w_ay, w_bx, w_byc;
    logic signed [MW:0] w_cv;
    logic signed [IW-1:0] w_nxt_step;
    logic w_by_eq, w_cv_ok;
    chs_pkg::t_point w_in_pt;

    chs_ram #(.WIDTH(2 * chs_pkg::CoordW), .DEPTH(MAX_POINTS)) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    chs_ram #(.WIDTH(IW), .DEPTH(SD)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    function automatic logic [SW-1:0] f_saddr(input logic [SW:0] base,
                                              input logic signed [XW-1:0] off);
        logic signed [XW-1:0] a;
        a = $signed({1'b0, base}) + off;
        if (a < 0) begin
            return '0;
        end else if (a > XW'(SD - 1)) begin
            return SW'(SD - 1);
        end
        return a[SW-1:0];
    endfunction

    function automatic logic f_before(input chs_pkg::t_point a, input chs_pkg::t_point b);
        return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
    endfunction

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_ax = $signed({r_pcur.x[chs_pkg::CoordW-1], r_pcur.x})
                - $signed({r_pprv.x[chs_pkg::CoordW-1], r_pprv.x});
    assign w_ay = $signed({r_pcur.y[chs_pkg::CoordW-1], r_pcur.y})
                - $signed({r_pprv.y[chs_pkg::CoordW-1], r_pprv.y});
    assign w_bx = $signed({r_pnxt.x[chs_pkg::CoordW-1], r_pnxt.x})
                - $signed({r_pcur.x[chs_pkg::CoordW-1], r_pcur.x});
    assign w_byc = $signed({r_pnxt.y[chs_pkg::CoordW-1], r_pnxt.y})
                 - $signed({r_pcur.y[chs_pkg::CoordW-1], r_pcur.y});
    assign w_cv = $signed({r_m1[MW-1], r_m1}) - $signed({r_m2[MW-1], r_m2});
    assign w_by_eq = r_sc_npos ? (r_by > 0) : (r_by < 0);
    assign w_cv_ok = r_sc_spos ? (w_cv > 0) : (w_cv < 0);
    assign w_nxt_step = r_dec ? (r_nxt - IW'(1)) : (r_nxt + IW'(1));
    assign w_in_pt.x = i_point_x;
    assign w_in_pt.y = i_point_y;

    always_comb begin
        n_state = r_state;
        n_ccw = r_ccw;
        n_cnt = r_cnt;
        n_drop = r_drop;
        n_si = r_si;
        n_sj = r_sj;
        n_mi = r_mi;
        n_v = r_v;
        n_lo = r_lo;
        n_hi = r_hi;
        n_loy = r_loy;
        n_hiy = r_hiy;
        n_p0 = r_p0;
        n_plast = r_plast;
        n_phase = r_phase;
        n_sc_start = r_sc_start;
        n_sc_end = r_sc_end;
        n_sc_base = r_sc_base;
        n_sc_npos = r_sc_npos;
        n_sc_spos = r_sc_spos;
        n_dec = r_dec;
        n_prv = r_prv;
        n_cur = r_cur;
        n_nxt = r_nxt;
        n_endadj = r_endadj;
        n_size = r_size;
        n_guard = r_guard;
        n_pprv = r_pprv;
        n_pcur = r_pcur;
        n_pnxt = r_pnxt;
        n_by = r_by;
        n_m1 = r_m1;
        n_m2 = r_m2;
        n_anz = r_anz;
        n_scnt = r_scnt;
        n_lc0 = r_lc0;
        n_lb = r_lb;
        n_lc = r_lc;
        n_rb = r_rb;
        n_rc = r_rc;
        n_stop = r_stop;
        n_stop_v = r_stop_v;
        n_chk_v = r_chk_v;
        n_pa = r_pa;
        n_em_side = r_em_side;
        n_em_i = r_em_i;
        n_new = r_new;
        n_pend = r_pend;
        n_pend_v = r_pend_v;
        n_hcnt = r_hcnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_pt = r_out_pt;
        n_out_last = r_out_last;
        n_out_ovf = r_out_ovf;

        p_we = 1'b0;
        p_waddr = '0;
        p_wdata = w_in_pt;
        p_raddr = '0;
        s_we = 1'b0;
        s_waddr = '0;
        s_wdata = '0;
        s_raddr = '0;

        if (i_cfg_valid) begin
            n_ccw = i_counter_clockwise;
        end

        case (r_state)
            chs_pkg::S_LOAD: begin
                if (i_in_valid) begin
                    if (r_cnt < CW'(MAX_POINTS)) begin
                        p_we = 1'b1;
                        p_waddr = r_cnt[AW-1:0];
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_point) begin
                        n_si = CW'(1);
                        n_mi = '0;
                        if (n_cnt > CW'(1)) begin
                            n_state = chs_pkg::S_SORT_RD;
                        end else begin
                            n_state = chs_pkg::S_MM_RD;
                        end
                    end
                end
            end
            chs_pkg::S_SORT_RD: begin
                p_raddr = r_si[AW-1:0];
                n_state = chs_pkg::S_SORT_V;
            end
            chs_pkg::S_SORT_V: begin
                n_v = p_rdata;
                n_sj = r_si;
                n_state = chs_pkg::S_SORT_J;
            end
            chs_pkg::S_SORT_J: begin
                if (r_sj == '0) begin
                    p_we = 1'b1;
                    p_waddr = '0;
                    p_wdata = r_v;
                    if (r_si + 1'b1 >= r_cnt) begin
                        n_state = chs_pkg::S_MM_RD;
                    end else begin
                        n_si = r_si + 1'b1;
                        n_state = chs_pkg::S_SORT_RD;
                    end
                end else begin
                    p_raddr = AW'(r_sj - 1'b1);
                    n_state = chs_pkg::S_SORT_CMP;
                end
            end
            chs_pkg::S_SORT_CMP: begin
                p_we = 1'b1;
                p_waddr = r_sj[AW-1:0];
                if (f_before(r_v, p_rdata)) begin
                    p_wdata = p_rdata;
                    n_sj = r_sj - 1'b1;
                    n_state = chs_pkg::S_SORT_J;
                end else begin
                    p_wdata = r_v;
                    if (r_si + 1'b1 >= r_cnt) begin
                        n_state = chs_pkg::S_MM_RD;
                    end else begin
                        n_si = r_si + 1'b1;
                        n_state = chs_pkg::S_SORT_RD;
                    end
                end
            end
            chs_pkg::S_MM_RD: begin
                p_raddr = r_mi[AW-1:0];
                n_state = chs_pkg::S_MM_CMP;
            end
            chs_pkg::S_MM_CMP: begin
                if (r_mi == '0) begin
                    n_lo = '0;
                    n_hi = '0;
                    n_loy = p_rdata.y;
                    n_hiy = p_rdata.y;
                    n_p0 = p_rdata;
                end else begin
                    if (r_loy > p_rdata.y) begin
                        n_lo = IW'(r_mi);
                        n_loy = p_rdata.y;
                    end
                    if (r_hiy < p_rdata.y) begin
                        n_hi = IW'(r_mi);
                        n_hiy = p_rdata.y;
                    end
                end
                if (r_mi + 1'b1 >= r_cnt) begin
                    n_plast = p_rdata;
                    n_state = chs_pkg::S_DECIDE;
                end else begin
                    n_mi = r_mi + 1'b1;
                    n_state = chs_pkg::S_MM_RD;
                end
            end
            chs_pkg::S_DECIDE: begin
                n_hcnt = '0;
                if (r_p0 == r_plast) begin
                    n_pend = r_p0;
                    n_pend_v = 1'b1;
                    n_state = chs_pkg::S_FLUSH;
                end else begin
                    n_phase = 2'd0;
                    n_sc_start = '0;
                    n_sc_end = r_hi;
                    n_sc_base = '0;
                    n_sc_npos = 1'b0;
                    n_sc_spos = 1'b1;
                    n_state = chs_pkg::S_SC_START;
                end
            end
            chs_pkg::S_SC_START: begin
                n_dec = r_sc_end < r_sc_start;
                if (r_sc_start == r_sc_end) begin
                    s_we = 1'b1;
                    s_waddr = f_saddr(r_sc_base, '0);
                    s_wdata = r_sc_start;
                    n_scnt = (SW + 1)'(1);
                    n_state = chs_pkg::S_SC_DONE;
                end else begin
                    p_raddr = r_sc_start[AW-1:0];
                    n_state = chs_pkg::S_SC_RS;
                end
            end
            chs_pkg::S_SC_RS: begin
                n_pprv = p_rdata;
                p_raddr = r_sc_end[AW-1:0];
                n_state = chs_pkg::S_SC_RE;
            end
            chs_pkg::S_SC_RE: begin
                s_we = 1'b1;
                s_waddr = f_saddr(r_sc_base, '0);
                s_wdata = r_sc_start;
                if (p_rdata == r_pprv) begin
                    n_scnt = (SW + 1)'(1);
                    n_state = chs_pkg::S_SC_DONE;
                end else begin
                    n_prv = r_sc_start;
                    n_cur = r_dec ? (r_sc_start - IW'(1)) : (r_sc_start + IW'(1));
                    n_nxt = r_dec ? (r_sc_start - IW'(2)) : (r_sc_start + IW'(2));
                    n_endadj = r_dec ? (r_sc_end - IW'(1)) : (r_sc_end + IW'(1));
                    n_size = (SW + 1)'(3);
                    n_guard = GW'(GUARD);
                    n_state = chs_pkg::S_SC_W1;
                end
            end
            chs_pkg::S_SC_W1: begin
                s_we = 1'b1;
                s_waddr = f_saddr(r_sc_base, XW'(1));
                s_wdata = r_cur;
                p_raddr = r_cur[AW-1:0];
                n_state = chs_pkg::S_SC_W2;
            end
            chs_pkg::S_SC_W2: begin
                s_we = 1'b1;
                s_waddr = f_saddr(r_sc_base, XW'(2));
                s_wdata = r_nxt;
                n_pcur = p_rdata;
                n_state = chs_pkg::S_SC_CHK;
            end
            chs_pkg::S_SC_CHK: begin
                if ((r_nxt == r_endadj) || (r_guard == '0)) begin
                    n_scnt = r_size - 1'b1;
                    n_state = chs_pkg::S_SC_DONE;
                end else begin
                    n_guard = r_guard - 1'b1;
                    p_raddr = r_nxt[AW-1:0];
                    n_state = chs_pkg::S_SC_FN;
                end
            end
            chs_pkg::S_SC_FN: begin
                n_pnxt = p_rdata;
                n_state = chs_pkg::S_SC_MUL;
            end
            chs_pkg::S_SC_MUL: begin
                n_by = w_byc;
                n_m1 = w_ay * w_bx;
                n_m2 = w_ax * w_byc;
                n_anz = (w_ax != '0) || (w_ay != '0);
                n_state = chs_pkg::S_SC_DEC;
            end
            chs_pkg::S_SC_DEC: begin
                if (w_by_eq) begin
                    n_nxt = w_nxt_step;
                    s_we = 1'b1;
                    s_waddr = f_saddr(r_sc_base, $signed({1'b0, r_size}) - XW'(1));
                    s_wdata = w_nxt_step;
                    n_state = chs_pkg::S_SC_CHK;
                end else if (w_cv_ok && r_anz) begin
                    n_prv = r_cur;
                    n_cur = r_nxt;
                    n_pprv = r_pcur;
                    n_pcur = r_pnxt;
                    n_nxt = w_nxt_step;
                    s_we = 1'b1;
                    s_waddr = f_saddr(r_sc_base, $signed({1'b0, r_size}));
                    s_wdata = w_nxt_step;
                    if (r_size < (SW + 1)'(SD)) begin
                        n_size = r_size + 1'b1;
                    end
                    n_state = chs_pkg::S_SC_CHK;
                end else if (r_prv == r_sc_start) begin
                    n_cur = r_nxt;
                    n_pcur = r_pnxt;
                    n_nxt = w_nxt_step;
                    s_we = 1'b1;
                    s_waddr = f_saddr(r_sc_base, XW'(1));
                    s_wdata = r_nxt;
                    n_state = chs_pkg::S_SC_WB2;
                end else begin
                    s_we = 1'b1;
                    s_waddr = f_saddr(r_sc_base, $signed({1'b0, r_size}) - XW'(2));
                    s_wdata = r_nxt;
                    s_raddr = f_saddr(r_sc_base, $signed({1'b0, r_size}) - XW'(4));
                    n_cur = r_prv;
                    n_pcur = r_pprv;
                    if (r_size > (SW + 1)'(1)) begin
                        n_size = r_size - 1'b1;
                    end
                    n_state = chs_pkg::S_SC_POP1;
                end
            end
            chs_pkg::S_SC_WB2: begin
                s_we = 1'b1;
                s_waddr = f_saddr(r_sc_base, XW'(2));
                s_wdata = r_nxt;
                n_state = chs_pkg::S_SC_CHK;
            end
            chs_pkg::S_SC_POP1: begin
                n_prv = s_rdata;
                p_raddr = s_rdata[AW-1:0];
                n_state = chs_pkg::S_SC_POP2;
            end
            chs_pkg::S_SC_POP2: begin
                n_pprv = p_rdata;
                n_state = chs_pkg::S_SC_CHK;
            end
            chs_pkg::S_SC_DONE: begin
                case (r_phase)
                    2'd0, 2'd2: begin
                        n_lc0 = r_scnt;
                        n_sc_start = IW'(r_cnt) - IW'(1);
                        n_sc_base = r_scnt;
                        n_sc_npos = r_phase[1];
                        n_sc_spos = r_phase[1];
                        n_phase = r_phase + 2'd1;
                        n_state = chs_pkg::S_SC_START;
                    end
                    default: begin
                        if (r_ccw == (r_phase == 2'd1)) begin
                            n_lb = r_sc_base;
                            n_lc = r_scnt;
                            n_rb = '0;
                            n_rc = r_lc0;
                        end else begin
                            n_lb = '0;
                            n_lc = r_lc0;
                            n_rb = r_sc_base;
                            n_rc = r_scnt;
                        end
                        if (r_phase == 2'd1) begin
                            n_state = chs_pkg::S_STOP_RD;
                        end else if (r_stop_v) begin
                            n_state = chs_pkg::S_CHK_RD;
                        end else begin
                            n_em_side = 1'b0;
                            n_em_i = '0;
                            n_state = chs_pkg::S_EM_NEXT;
                        end
                    end
                endcase
            end
            chs_pkg::S_STOP_RD: begin
                n_stop_v = (r_rc > (SW + 1)'(2)) || (r_lc > (SW + 1)'(2));
                if (r_rc > (SW + 1)'(2)) begin
                    s_raddr = f_saddr(r_rb, XW'(1));
                end else begin
                    s_raddr = f_saddr(r_lb, $signed({1'b0, r_lc}) - XW'(2));
                end
                n_state = chs_pkg::S_STOP_CAP;
            end
            chs_pkg::S_STOP_CAP: begin
                n_stop = s_rdata;
                n_stop_v = r_stop_v && !s_rdata[IW-1];
                n_em_side = 1'b0;
                n_em_i = '0;
                n_state = chs_pkg::S_EM_NEXT;
            end
            chs_pkg::S_CHK_RD: begin
                n_chk_v = (r_lc > (SW + 1)'(2))
                       || (({1'b0, r_lc} + {1'b0, r_rc}) > (SW + 2)'(2));
                if (r_lc > (SW + 1)'(2)) begin
                    s_raddr = f_saddr(r_lb, XW'(1));
                end else begin
                    s_raddr = f_saddr(r_rb, XW'(2) - $signed({1'b0, r_lc}));
                end
                n_state = chs_pkg::S_CHK_CAP;
            end
            chs_pkg::S_CHK_CAP: begin
                n_em_side = 1'b0;
                n_em_i = '0;
                if (!r_chk_v || s_rdata[IW-1]) begin
                    n_state = chs_pkg::S_EM_NEXT;
                end else if ($signed(s_rdata) == r_stop) begin
                    n_lc = (r_lc > (SW + 1)'(2)) ? (SW + 1)'(2) : r_lc;
                    n_rc = (r_rc > (SW + 1)'(2)) ? (SW + 1)'(2) : r_rc;
                    n_state = chs_pkg::S_EM_NEXT;
                end else begin
                    p_raddr = s_rdata[AW-1:0];
                    n_state = chs_pkg::S_CHK_P1;
                end
            end
            chs_pkg::S_CHK_P1: begin
                n_pa = p_rdata;
                p_raddr = r_stop[AW-1:0];
                n_state = chs_pkg::S_CHK_P2;
            end
            chs_pkg::S_CHK_P2: begin
                if (p_rdata == r_pa) begin
                    n_lc = (r_lc > (SW + 1)'(2)) ? (SW + 1)'(2) : r_lc;
                    n_rc = (r_rc > (SW + 1)'(2)) ? (SW + 1)'(2) : r_rc;
                end
                n_state = chs_pkg::S_EM_NEXT;
            end
            chs_pkg::S_EM_NEXT: begin
                if (!r_em_side) begin
                    if (r_em_i + 1'b1 < r_lc) begin
                        s_raddr = f_saddr(r_lb, $signed({1'b0, r_em_i}));
                        n_state = chs_pkg::S_EM_IDX;
                    end else begin
                        n_em_side = 1'b1;
                        n_em_i = r_rc - 1'b1;
                    end
                end else if (r_em_i != '0) begin
                    s_raddr = f_saddr(r_rb, $signed({1'b0, r_em_i}));
                    n_state = chs_pkg::S_EM_IDX;
                end else if (r_phase == 2'd1) begin
                    n_phase = 2'd2;
                    n_sc_start = '0;
                    n_sc_end = r_lo;
                    n_sc_base = '0;
                    n_sc_npos = 1'b1;
                    n_sc_spos = 1'b0;
                    n_state = chs_pkg::S_SC_START;
                end else begin
                    n_state = chs_pkg::S_FLUSH;
                end
            end
            chs_pkg::S_EM_IDX: begin
                p_raddr = s_rdata[AW-1:0];
                n_state = chs_pkg::S_EM_PT;
            end
            chs_pkg::S_EM_PT: begin
                n_new = p_rdata;
                n_state = chs_pkg::S_EM_PUSH;
            end
            chs_pkg::S_EM_PUSH: begin
                if (r_hcnt >= CW'(MAX_POINTS) || !r_pend_v || w_out_free) begin
                    if (r_hcnt < CW'(MAX_POINTS)) begin
                        if (r_pend_v) begin
                            n_out_valid = 1'b1;
                            n_out_pt = r_pend;
                            n_out_last = 1'b0;
                            n_out_ovf = r_drop;
                        end
                        n_pend = r_new;
                        n_pend_v = 1'b1;
                        n_hcnt = r_hcnt + 1'b1;
                    end
                    n_em_i = r_em_side ? (r_em_i - 1'b1) : (r_em_i + 1'b1);
                    n_state = chs_pkg::S_EM_NEXT;
                end
            end
            chs_pkg::S_FLUSH: begin
                if (!r_pend_v || w_out_free) begin
                    if (r_pend_v) begin
                        n_out_valid = 1'b1;
                        n_out_pt = r_pend;
                        n_out_last = 1'b1;
                        n_out_ovf = r_drop;
                    end
                    n_pend_v = 1'b0;
                    n_cnt = '0;
                    n_drop = 1'b0;
                    n_state = chs_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = chs_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chs_pkg::S_LOAD;
            r_ccw <= 1'b0;
            r_cnt <= '0;
            r_drop <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_valid <= 1'b0;
            r_stop_v <= 1'b0;
            r_phase <= 2'd0;
        end else begin
            r_state <= n_state;
            r_ccw <= n_ccw;
            r_cnt <= n_cnt;
            r_drop <= n_drop;
            r_pend_v <= n_pend_v;
            r_out_valid <= n_out_valid;
            r_stop_v <= n_stop_v;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si <= n_si;
        r_sj <= n_sj;
        r_mi <= n_mi;
        r_v <= n_v;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_loy <= n_loy;
        r_hiy <= n_hiy;
        r_p0 <= n_p0;
        r_plast <= n_plast;
        r_sc_start <= n_sc_start;
        r_sc_end <= n_sc_end;
        r_sc_base <= n_sc_base;
        r_sc_npos <= n_sc_npos;
        r_sc_spos <= n_sc_spos;
        r_dec <= n_dec;
        r_prv <= n_prv;
        r_cur <= n_cur;
        r_nxt <= n_nxt;
        r_endadj <= n_endadj;
        r_size <= n_size;
        r_guard <= n_guard;
        r_pprv <= n_pprv;
        r_pcur <= n_pcur;
        r_pnxt <= n_pnxt;
        r_by <= n_by;
        r_m1 <= n_m1;
        r_m2 <= n_m2;
        r_anz <= n_anz;
        r_scnt <= n_scnt;
        r_lc0 <= n_lc0;
        r_lb <= n_lb;
        r_lc <= n_lc;
        r_rb <= n_rb;
        r_rc <= n_rc;
        r_stop <= n_stop;
        r_chk_v <= n_chk_v;
        r_pa <= n_pa;
        r_em_side <= n_em_side;
        r_em_i <= n_em_i;
        r_new <= n_new;
        r_pend <= n_pend;
        r_hcnt <= n_hcnt;
        r_out_pt <= n_out_pt;
        r_out_last <= n_out_last;
        r_out_ovf <= n_out_ovf;
    end

    assign o_in_stall = (r_state != chs_pkg::S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_hull_x = r_out_pt.x;
    assign o_hull_y = r_out_pt.y;
    assign o_hull_last = r_out_last;
    assign o_overflow = r_out_ovf;

endmodule

// File: rtl/chs_ram.sv
module chs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
